@@ hdl/segment_memory_manager_assert.svh @@
// Assertion macros shared by the segment memory manager.
// Each macro names its label, the condition, the consequence and the message.
`ifndef SEGMENT_MEMORY_MANAGER_ASSERT_SVH
`define SEGMENT_MEMORY_MANAGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/smm_pkg.sv @@
package smm_pkg;

  // Default sizes
  localparam int DEF_MAX_SEGMENTS      = 64;
  localparam int DEF_MAX_SEGMENT_WORDS = 1024;

  // Field widths
  localparam int FUNC_W      = 2;
  localparam int WORD_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int CFG_W       = 11;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 40;

  // Reset value of the segment zero length register before capping
  localparam int SEG0_LEN_RESET = 1024;

  // Operations
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MAP   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNMAP = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic accept;
    logic check;
    logic fill;
    logic resp;
  } smm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic fill_start;
    logic fill_last;
    logic out_free;
  } smm_sts_t;

endpackage

@@ hdl/segment_memory_manager.sv @@
// Segmented word memory: one transaction in carries load, store, map or
// unmap and gives exactly one result transaction out. After reset the block
// runs a clearing pass over every entry of the segment table before
// it takes its first item; configuration writes are taken throughout. Items
// are handled one at a time: load, store, unmap and any refused request go
// through accept, table check and response register, and a successful map
// of nonzero length adds a fill step that zero-fills the new segment word by
// word through the single write port of the word memory. The
// result register lets a finished result wait for the sink while the block
// returns to accepting.
`include "segment_memory_manager_assert.svh"

module segment_memory_manager #(
  parameter int MAX_SEGMENTS      = smm_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_SEGMENT_WORDS = smm_pkg::DEF_MAX_SEGMENT_WORDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // fields from bit 0: func[1:0], seg_id[33:2], word_offset[65:34],
  // store_value[97:66], map_length[129:98], zero[135:130]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // fields from bit 0: read_data[31:0], status[34:32], zero[39:35]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [smm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // program_segment_length
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smm_pkg::CFG_W-1:0]       cfg_data
);
  import smm_pkg::*;

  smm_cmd_t cmd;
  smm_sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  smm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smm_dp #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .MAX_SEGMENT_WORDS (MAX_SEGMENT_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // One item in flight: no new transaction right after acceptance
  `SMM_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "item accepted while busy")
  // At most one controller command at a time
  `SMM_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.clear, cmd.check, cmd.fill, cmd.resp}), "overlapping commands")
  // Result status stays within its defined codes
  `SMM_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[34:32] <= ST_TOO_LONG, "bad status code")

endmodule

@@ hdl/smm_ctrl.sv @@
module smm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  smm_pkg::smm_sts_t sts,
  output smm_pkg::smm_cmd_t cmd
);
  import smm_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_FILL  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from the current state
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    state_nxt  = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.fill_start ? S_FILL : S_RESP;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/smm_dp.sv @@
module smm_dp #(
  parameter int MAX_SEGMENTS      = smm_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_SEGMENT_WORDS = smm_pkg::DEF_MAX_SEGMENT_WORDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [smm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             cfg_we,
  input  logic [smm_pkg::CFG_W-1:0]        cfg_data,
  input  smm_pkg::smm_cmd_t                cmd,
  output smm_pkg::smm_sts_t                sts,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [smm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import smm_pkg::*;

  localparam int SEG_W    = $clog2(MAX_SEGMENTS);
  localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int LEN_W    = $clog2(MAX_SEGMENT_WORDS + 1);
  localparam int OFF_W    = (MAX_SEGMENT_WORDS > 1) ? $clog2(MAX_SEGMENT_WORDS) : 1;
  localparam int ADDR_W   = SEG_W + OFF_W;
  localparam int WORDS_N  = MAX_SEGMENTS * (2 ** OFF_W);
  localparam int SEG0_RST = (SEG0_LEN_RESET > MAX_SEGMENT_WORDS) ?
                            MAX_SEGMENT_WORDS : SEG0_LEN_RESET;
  localparam int PAD_W    = OUT_TDATA_W - STATUS_W - WORD_W;

  // Memories: segment words, {mapped, length} per id, free id stack
  logic [WORD_W-1:0] words_mem [WORDS_N];
  logic [LEN_W:0]    tbl_mem   [MAX_SEGMENTS];
  logic [SEG_W-1:0]  stk_mem   [MAX_SEGMENTS];

  // Item registers
  logic [FUNC_W-1:0] func_r;
  logic [WORD_W-1:0] id_r;
  logic [WORD_W-1:0] off_r;
  logic [WORD_W-1:0] val_r;
  logic [WORD_W-1:0] len_r;

  logic [LEN_W:0]       tbl_q_r;
  logic [SEG_W-1:0]     stk_q_r;
  logic [WORD_W-1:0]    word_q_r;
  logic [CNT_W-1:0]     stk_cnt_r,  stk_cnt_nxt;
  logic [CNT_W-1:0]     fresh_r,    fresh_nxt;
  logic [LEN_W-1:0]     seg0_len_r;
  logic [SEG_W-1:0]     clr_cnt_r;
  logic [LEN_W-1:0]     fill_cnt_r;
  logic [SEG_W-1:0]     nid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [WORD_W-1:0]    data_r;
  logic                 rd_sel_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [LEN_W-1:0]     cfg_len;
  logic                 id_in_range, id_zero, live, off_ok;
  logic [LEN_W-1:0]     seg_len;
  logic                 too_long, no_id, map_ok, unmap_ok, acc_ok;
  logic [SEG_W-1:0]     nid;
  logic [STATUS_W-1:0]  chk_status;
  logic                 tbl_we;
  logic [SEG_W-1:0]     tbl_waddr;
  logic [LEN_W:0]       tbl_wdata;
  logic                 words_we;
  logic [ADDR_W-1:0]    words_waddr;
  logic [WORD_W-1:0]    words_wdata;
  logic [ADDR_W-1:0]    words_raddr;
  logic                 stk_we;
  logic [SEG_W-1:0]     stk_top;

  // Cap the configured length of segment zero
  assign cfg_len = ({21'd0, cfg_data} > 32'(MAX_SEGMENT_WORDS)) ?
                   LEN_W'(MAX_SEGMENT_WORDS) : LEN_W'(cfg_data);

  // Check the item against the segment table
  assign id_in_range = id_r < 32'(MAX_SEGMENTS);
  assign id_zero     = id_r == '0;
  assign live        = id_in_range && (id_zero || tbl_q_r[LEN_W]);
  assign seg_len     = id_zero ? seg0_len_r : tbl_q_r[LEN_W-1:0];
  assign off_ok      = off_r < 32'(seg_len);
  assign acc_ok      = live && off_ok;
  assign too_long    = len_r > 32'(MAX_SEGMENT_WORDS);
  assign no_id       = (stk_cnt_r == '0) && (fresh_r >= CNT_W'(MAX_SEGMENTS));
  assign map_ok      = (func_r == FUNC_MAP) && !too_long && !no_id;
  assign unmap_ok    = (func_r == FUNC_UNMAP) && !id_zero && live;
  assign nid         = (stk_cnt_r != '0) ? stk_q_r : fresh_r[SEG_W-1:0];
  assign stk_top     = SEG_W'(stk_cnt_r - CNT_W'(1));

  always_comb begin
    case (func_r)
      FUNC_LOAD, FUNC_STORE: begin
        chk_status = !live ? ST_UNMAPPED : (!off_ok ? ST_OFFSET : ST_OK);
      end
      FUNC_MAP: begin
        chk_status = too_long ? ST_TOO_LONG : (no_id ? ST_NO_ID : ST_OK);
      end
      default: begin
        chk_status = unmap_ok ? ST_OK : ST_UNMAPPED;
      end
    endcase
  end

  // Segment table write port
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_cnt_r;
    tbl_wdata = '0;
    if (cmd.clear) begin
      tbl_we = 1'b1;
    end else if (cmd.check && map_ok) begin
      tbl_we    = 1'b1;
      tbl_waddr = nid;
      tbl_wdata = {1'b1, len_r[LEN_W-1:0]};
    end else if (cmd.check && unmap_ok) begin
      tbl_we    = 1'b1;
      tbl_waddr = id_r[SEG_W-1:0];
    end
  end

  // Word memory ports: store in check, zeros during fill
  assign words_raddr = {id_r[SEG_W-1:0], off_r[OFF_W-1:0]};
  always_comb begin
    words_we    = 1'b0;
    words_waddr = words_raddr;
    words_wdata = val_r;
    if (cmd.check && (func_r == FUNC_STORE) && acc_ok) begin
      words_we = 1'b1;
    end else if (cmd.fill) begin
      words_we    = 1'b1;
      words_waddr = {nid_r, fill_cnt_r[OFF_W-1:0]};
      words_wdata = '0;
    end
  end

  // Free id stack and fresh id bookkeeping
  assign stk_we = cmd.check && unmap_ok && (stk_cnt_r < CNT_W'(MAX_SEGMENTS));
  always_comb begin
    stk_cnt_nxt = stk_cnt_r;
    fresh_nxt   = fresh_r;
    if (cmd.check && map_ok) begin
      if (stk_cnt_r != '0) begin
        stk_cnt_nxt = stk_cnt_r - CNT_W'(1);
      end else begin
        fresh_nxt = fresh_r + CNT_W'(1);
      end
    end else if (stk_we) begin
      stk_cnt_nxt = stk_cnt_r + CNT_W'(1);
    end
  end

  // Memory accesses
  always_ff @(posedge clk) begin
    if (words_we) begin
      words_mem[words_waddr] <= words_wdata;
    end
    if (cmd.check) begin
      word_q_r <= words_mem[words_raddr];
    end
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q_r <= tbl_mem[in_tdata[FUNC_W +: SEG_W]];
    if (stk_we) begin
      stk_mem[stk_cnt_r[SEG_W-1:0]] <= id_r[SEG_W-1:0];
    end
    stk_q_r <= stk_mem[stk_top];
  end

  // Capture the item and the check result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_tdata[0 +: FUNC_W];
      id_r   <= in_tdata[FUNC_W +: WORD_W];
      off_r  <= in_tdata[FUNC_W + WORD_W +: WORD_W];
      val_r  <= in_tdata[FUNC_W + 2*WORD_W +: WORD_W];
      len_r  <= in_tdata[FUNC_W + 3*WORD_W +: WORD_W];
    end
    if (cmd.check) begin
      status_r <= chk_status;
      nid_r    <= nid;
      data_r   <= map_ok ? WORD_W'(nid) : '0;
      rd_sel_r <= (func_r == FUNC_LOAD) && acc_ok;
    end
    if (cmd.resp && sts.out_free) begin
      out_tdata_r <= {{PAD_W{1'b0}}, status_r, rd_sel_r ? word_q_r : data_r};
    end
  end

  // Hold the output register until taken
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_valid_nxt = (cmd.resp && sts.out_free) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  // Sequence status
  assign sts.clear_last = clr_cnt_r == SEG_W'(MAX_SEGMENTS - 1);
  assign sts.fill_start = map_ok && (len_r != '0);
  assign sts.fill_last  = fill_cnt_r == (len_r[LEN_W-1:0] - LEN_W'(1));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r   <= '0;
      fresh_r     <= CNT_W'(1);
      seg0_len_r  <= LEN_W'(SEG0_RST);
      clr_cnt_r   <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stk_cnt_r   <= stk_cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seg0_len_r <= cfg_len;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + SEG_W'(1);
      end
      if (cmd.check) begin
        fill_cnt_r <= '0;
      end else if (cmd.fill) begin
        fill_cnt_r <= fill_cnt_r + LEN_W'(1);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ tb/testbench.sv @@
module testbench;
  import smm_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int NUM_SEGS      = DEF_MAX_SEGMENTS;
  localparam int SEG_WORDS     = DEF_MAX_SEGMENT_WORDS;
  localparam int ID_W          = $clog2(NUM_SEGS);
  localparam int NUM_DIRECTED  = 25;
  localparam int PHASE_ITEMS   = 642;
  localparam int NUM_PHASES    = 3;
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int SEG0_WINDOW   = 48;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] seg_id;
    logic [WORD_W-1:0] word_offset;
    logic [WORD_W-1:0] store_value;
    logic [WORD_W-1:0] map_length;
  } mem_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } mem_rsp_t;

  typedef struct packed {
    mem_req_t req;
    logic     typed;
    mem_rsp_t rsp;
  } directed_row_t;

  // Directed rows: request, whether the result is typed in, typed result
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // unmapped and out-of-range ids
    '{'{FUNC_LOAD,  32'd1,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    '{'{FUNC_LOAD,  32'hFFFF_FFFF, 32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    // program segment edges at reset length
    '{'{FUNC_STORE, 32'd0,         32'd0,         32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, '{32'd0, ST_OK}},
    '{'{FUNC_STORE, 32'd0,         32'd1023,      32'hA5C3_0F96, 32'd0},
      1'b1, '{32'd0, ST_OK}},
    '{'{FUNC_LOAD,  32'd0,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'hFFFF_FFFF, ST_OK}},
    '{'{FUNC_LOAD,  32'd0,         32'd1023,      32'hFFFF_FFFF, 32'd0},
      1'b0, '{32'd0, ST_OK}},
    '{'{FUNC_LOAD,  32'd0,         32'd1024,      32'd0,         32'd0},
      1'b1, '{32'd0, ST_OFFSET}},
    '{'{FUNC_STORE, 32'd0,         32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'd0},
      1'b1, '{32'd0, ST_OFFSET}},
    // oversized maps
    '{'{FUNC_MAP,   32'd0,         32'd0,         32'd0,         32'hFFFF_FFFF},
      1'b1, '{32'd0, ST_TOO_LONG}},
    '{'{FUNC_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         32'd1025},
      1'b1, '{32'd0, ST_TOO_LONG}},
    // fresh ids: full length, then zero length
    '{'{FUNC_MAP,   32'd0,         32'd0,         32'd0,         32'd1024},
      1'b1, '{32'd1, ST_OK}},
    '{'{FUNC_MAP,   32'd0,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd2, ST_OK}},
    '{'{FUNC_LOAD,  32'd2,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_OFFSET}},
    '{'{FUNC_LOAD,  32'd1,         32'd1023,      32'd0,         32'd0},
      1'b1, '{32'd0, ST_OK}},
    '{'{FUNC_STORE, 32'd1,         32'd5,         32'h1234_5678, 32'd0},
      1'b1, '{32'd0, ST_OK}},
    '{'{FUNC_LOAD,  32'd1,         32'd5,         32'd0,         32'd0},
      1'b0, '{32'd0, ST_OK}},
    // unmap refusals and frees
    '{'{FUNC_UNMAP, 32'd0,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    '{'{FUNC_UNMAP, 32'd64,        32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    '{'{FUNC_UNMAP, 32'd1,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_OK}},
    '{'{FUNC_UNMAP, 32'd1,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    '{'{FUNC_STORE, 32'd1,         32'd5,         32'hDEAD_BEEF, 32'd0},
      1'b1, '{32'd0, ST_UNMAPPED}},
    '{'{FUNC_UNMAP, 32'd2,         32'd0,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_OK}},
    // freed ids return last in, first out
    '{'{FUNC_MAP,   32'd0,         32'd0,         32'd0,         32'd3},
      1'b1, '{32'd2, ST_OK}},
    '{'{FUNC_MAP,   32'd0,         32'd0,         32'd0,         32'd7},
      1'b1, '{32'd1, ST_OK}},
    '{'{FUNC_LOAD,  32'd1,         32'd5,         32'd0,         32'd0},
      1'b1, '{32'd0, ST_OK}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // fields from bit 0: func, seg_id, word_offset, store_value, map_length, zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // fields from bit 0: read_data, status, zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Shadow copy of the segment memory state
  logic [WORD_W-1:0] word_mem [NUM_SEGS*SEG_WORDS];
  logic [CFG_W-1:0]  seg_len [NUM_SEGS];
  logic              seg_live [NUM_SEGS];
  logic [ID_W-1:0]   freed_ids [NUM_SEGS];
  int unsigned       freed_count;
  int unsigned       fresh_id;
  logic              seg0_stored [SEG_WORDS];

  mem_rsp_t          pending_rsps [$];
  mem_rsp_t          got_rsp;
  mem_rsp_t          want_rsp;
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  segment_memory_manager u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Apply one operation to the shadow state and return its result
  function automatic mem_rsp_t apply_mem_op(input mem_req_t req);
    mem_rsp_t    rsp;
    int unsigned slot;
    int unsigned w;
    rsp = '{read_data: '0, status: ST_OK};
    case (req.func)
      FUNC_LOAD, FUNC_STORE: begin
        if (req.seg_id >= NUM_SEGS || !seg_live[req.seg_id[ID_W-1:0]]) begin
          rsp.status = ST_UNMAPPED;
        end else if (req.word_offset >= seg_len[req.seg_id[ID_W-1:0]]) begin
          rsp.status = ST_OFFSET;
        end else begin
          slot = req.seg_id * SEG_WORDS + req.word_offset;
          if (req.func == FUNC_LOAD) begin
            rsp.read_data = word_mem[slot];
          end else begin
            word_mem[slot] = req.store_value;
            if (req.seg_id == 0) seg0_stored[req.word_offset] = 1'b1;
          end
        end
      end
      FUNC_MAP: begin
        if (req.map_length > SEG_WORDS) begin
          rsp.status = ST_TOO_LONG;
        end else if (freed_count == 0 && fresh_id >= NUM_SEGS) begin
          rsp.status = ST_NO_ID;
        end else begin
          // reuse the last freed id, else take a fresh one
          if (freed_count != 0) begin
            freed_count--;
            slot = freed_ids[freed_count];
          end else begin
            slot = fresh_id;
            fresh_id++;
          end
          for (w = 0; w < req.map_length; w++) word_mem[slot * SEG_WORDS + w] = '0;
          seg_len[slot]  = req.map_length[CFG_W-1:0];
          seg_live[slot] = 1'b1;
          rsp.read_data  = slot;
        end
      end
      default: begin
        if (req.seg_id == 0 || req.seg_id >= NUM_SEGS || !seg_live[req.seg_id[ID_W-1:0]]) begin
          rsp.status = ST_UNMAPPED;
        end else begin
          seg_live[req.seg_id[ID_W-1:0]] = 1'b0;
          seg_len[req.seg_id[ID_W-1:0]]  = '0;
          freed_ids[freed_count] = req.seg_id[ID_W-1:0];
          freed_count++;
        end
      end
    endcase
    return rsp;
  endfunction

  // Drive one request and hold it until the transaction completes
  task automatic send_req(input mem_req_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - FUNC_W - 4 * WORD_W){1'b0}},
                  req.map_length, req.store_value, req.word_offset, req.seg_id, req.func};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop the request and wait until every result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
  endtask

  // Write the segment zero length while the block is idle
  task automatic write_seg0_len(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    seg_len[0] = (value > SEG_WORDS) ? CFG_W'(SEG_WORDS) : value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stall the result channel at random
  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rsp = '{read_data: out_tdata[WORD_W-1:0], status: out_tdata[WORD_W +: STATUS_W]};
      if (pending_rsps.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: read_data %h status %0d",
                   got_rsp.read_data, got_rsp.status);
      end else begin
        want_rsp = pending_rsps.pop_front();
        if (got_rsp.read_data !== want_rsp.read_data || got_rsp.status !== want_rsp.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result mismatch: read_data %h (expected %h) status %0d (expected %0d)",
                     got_rsp.read_data, want_rsp.read_data, got_rsp.status, want_rsp.status);
        end
      end
    end
  end

  initial begin
    mem_req_t req;
    mem_rsp_t rsp;
    int       idx;
    int       n;
    int       phase_num;
    int       map_pct;
    int       unmap_pct;
    int       roll;
    int       lroll;
    int       len_now;
    int       live_ids [$];

    // Reset the shadow state: only segment zero mapped
    for (idx = 0; idx < NUM_SEGS; idx++) begin
      seg_len[idx]  = '0;
      seg_live[idx] = 1'b0;
    end
    for (idx = 0; idx < SEG_WORDS; idx++) seg0_stored[idx] = 1'b0;
    seg_len[0]  = (SEG0_LEN_RESET > SEG_WORDS) ? CFG_W'(SEG_WORDS) : CFG_W'(SEG0_LEN_RESET);
    seg_live[0] = 1'b1;
    freed_count = 0;
    fresh_id    = 1;
    map_pct     = 25;

    send_idle_pct  = 10;
    recv_stall_pct = 57;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset length
    for (idx = 0; idx < NUM_DIRECTED; idx++) begin
      send_req(DIRECTED_ROWS[idx].req);
      rsp = apply_mem_op(DIRECTED_ROWS[idx].req);
      pending_rsps.push_back(DIRECTED_ROWS[idx].typed ? DIRECTED_ROWS[idx].rsp : rsp);
    end

    for (phase_num = 0; phase_num < NUM_PHASES; phase_num++) begin
      case (phase_num)
        0: begin
          write_seg0_len(CFG_W'(2047));
          send_idle_pct  = 10;
          recv_stall_pct = 57;
        end
        1: begin
          write_seg0_len('0);
          send_idle_pct  = 57;
          recv_stall_pct = 10;
        end
        default: begin
          write_seg0_len(CFG_W'($urandom_range(1, SEG_WORDS - 1)));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Shift the map/unmap balance to fill up and drain the id space
        if (n % 100 == 0) begin
          case ($urandom_range(0, 2))
            0:       map_pct = 10;
            1:       map_pct = 25;
            default: map_pct = 60;
          endcase
        end
        unmap_pct = (100 - map_pct) / 4;

        live_ids.delete();
        for (idx = 0; idx < NUM_SEGS; idx++) if (seg_live[idx]) live_ids.push_back(idx);

        req.seg_id      = live_ids[$urandom_range(0, live_ids.size() - 1)];
        req.word_offset = $urandom();
        req.store_value = $urandom();
        req.map_length  = $urandom();
        if ($urandom_range(0, 9) == 0)
          req.seg_id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, NUM_SEGS);

        roll = $urandom_range(0, 99);
        if (roll < map_pct) begin
          req.func = FUNC_MAP;
          lroll = $urandom_range(0, 99);
          if (lroll < 5)       req.map_length = $urandom();
          else if (lroll < 8)  req.map_length = SEG_WORDS + 1;
          else if (lroll < 10) req.map_length = SEG_WORDS;
          else if (lroll < 20) req.map_length = 0;
          else                 req.map_length = $urandom_range(1, 24);
        end else if (roll < map_pct + unmap_pct) begin
          req.func = FUNC_UNMAP;
        end else begin
          req.func = $urandom_range(0, 1) ? FUNC_LOAD : FUNC_STORE;
          len_now = seg_len[req.seg_id[ID_W-1:0]];
          if (len_now != 0 && $urandom_range(0, 7) != 0) begin
            // keep program segment traffic on a small window so loads hit
            if (req.seg_id == 0 && $urandom_range(0, 3) != 0)
              req.word_offset = $urandom_range(0, (len_now < SEG0_WINDOW ? len_now : SEG0_WINDOW) - 1);
            else
              req.word_offset = $urandom_range(0, len_now - 1);
          end else if ($urandom_range(0, 1) == 0) begin
            req.word_offset = len_now;
          end
        end

        // Never load a program word that was not stored first
        if (req.func == FUNC_LOAD && req.seg_id == 0 && req.word_offset < seg_len[0] &&
            !seg0_stored[req.word_offset])
          req.func = FUNC_STORE;

        send_req(req);
        pending_rsps.push_back(apply_mem_op(req));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
